FILE: rtl/task_delay_timeout_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delay and timeout queue.
// Each macro expands to one concurrent assertion, or to nothing when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TASK_DELAY_TIMEOUT_QUEUE_CORE_DEFINES_SVH
`define TASK_DELAY_TIMEOUT_QUEUE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge outside of reset.
`define TDQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Checks that a condition implies a consequence at the same edge.
`define TDQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Checks that a condition implies a consequence at the next edge.
`define TDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TDQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define TDQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TDQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// Task delay queue package
// Shared types and codes for the delay and timeout queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

   // Default sizes.
   localparam int unsigned MAX_ENTRIES_DEF = 16;
   localparam int unsigned TICK_BITS_DEF   = 32;
   localparam int unsigned ID_BITS_DEF     = 8;

   // Request kinds.
   localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
   localparam logic [1:0] REQ_REMOVE   = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   // Wait kinds reported with the request.
   localparam logic [1:0] WAIT_NONE        = 2'd0;
   localparam logic [1:0] WAIT_SEM         = 2'd1;
   localparam logic [1:0] WAIT_DELAY       = 2'd2;
   localparam logic [1:0] WAIT_SEM_TIMEOUT = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_INVAL = 3'd1;
   localparam logic [2:0] ST_DUP   = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_STATE = 3'd4;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/task_delay_timeout_queue_core.sv
// ----------------------------------------------------------------------------
// Task delay and timeout queue
// Ordered table of waiting tasks held in one entry memory, with enqueue,
// removal of semaphore-timeout waiters and a tick that expires entries.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   req_     in         tuser request kind, tdata task and wait details
//   rsp_     out        tdata status, expired task, counts; tlast ends item
//
// One item is worked on at a time. Each operation that passes its checks
// scans the queued entries through the entry memory, each in a read state
// and then an evaluate and write-back state, and closes with a finish state
// for the final beat. A tick emits one beat per expired entry and then a
// closing beat. A stalled result channel holds the scan.
// Reset clears the entry count at once; no memory clearing is needed.
`default_nettype none

`include "task_delay_timeout_queue_core_defines.svh"

module task_delay_timeout_queue_core
   import tdq_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int unsigned TICK_BITS   = TICK_BITS_DEF,
   parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] task_id, [39:8] wait_ticks, [40] task_found, [41] task_waiting,
   // [43:42] wait_kind, [47:44] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] status, [10:3] expired_task, [11] expired_kind,
   // [16:12] expired_total, [21:17] held_count, [23:22] zero
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast
);

   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef struct packed {
      logic                 sem;
      logic [TICK_BITS-1:0] rem;
      logic [ID_BITS-1:0]   task_id;
   } entry_type;

   // Entry memory and its registered read port.
   entry_type entry_mem [MAX_ENTRIES];
   entry_type mem_q;
   logic      mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type mem_wdata;

   // Control and request registers.
   state_type state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic                 semk_ff, semk_in;
   logic [2:0]           pre_ff, pre_in;
   logic                 hit_ff, hit_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     wr_ff, wr_in;
   logic [CNT_W-1:0]     exp_ff, exp_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_load;
   logic [23:0] rsp_data_in;
   logic        rsp_last_in;
   logic        out_free;

   // Request decode.
   logic [1:0]           req_type;
   logic [ID_BITS-1:0]   req_id;
   logic [TICK_BITS-1:0] req_ticks;
   logic                 req_found;
   logic                 req_waiting;
   logic [1:0]           req_kind;
   logic [2:0]           pre_status;
   logic                 accept;

   // Evaluation of the entry just read.
   logic [TICK_BITS-1:0] rem_dec;
   logic                 drop;
   logic                 stall;
   logic                 scan_done;

   assign req_type    = req_tuser;
   assign req_id      = ID_BITS'(req_tdata[7:0]);
   assign req_ticks   = TICK_BITS'(req_tdata[39:8]);
   assign req_found   = req_tdata[40];
   assign req_waiting = req_tdata[41];
   assign req_kind    = req_tdata[43:42];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Checks that need no table scan, in the order the operation defines.
   always_comb begin
      pre_status = ST_OK;
      unique case (req_type)
         REQ_ENQUEUE: begin
            if (req_ticks == '0 || !req_found) begin
               pre_status = ST_INVAL;
            end else if (!req_waiting ||
                         (req_kind != WAIT_DELAY && req_kind != WAIT_SEM_TIMEOUT)) begin
               pre_status = ST_STATE;
            end else if (req_id == '0) begin
               pre_status = ST_INVAL;
            end
         end
         REQ_REMOVE: begin
            if (req_id == '0 || !req_found) begin
               pre_status = ST_INVAL;
            end else if (!req_waiting || req_kind != WAIT_SEM_TIMEOUT) begin
               pre_status = ST_STATE;
            end
         end
         REQ_TICK: begin
            pre_status = ST_OK;
         end
         default: begin
            pre_status = ST_INVAL;
         end
      endcase
   end

   // Decision for the entry held in the read register.
   always_comb begin
      rem_dec = (mem_q.rem == '0) ? '0 : mem_q.rem - 1'b1;
      drop    = 1'b0;
      if (op_ff == REQ_TICK) begin
         drop = (rem_dec == '0);
      end else if (op_ff == REQ_REMOVE) begin
         drop = (mem_q.task_id == id_ff);
      end
      stall     = (op_ff == REQ_TICK) && drop && !out_free;
      scan_done = (rd_ff + 1'b1 == count_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (pre_status == ST_OK && count_ff != '0) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!stall) begin
               state_in = scan_done ? S_FINISH : S_READ;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control, memory writes and result beats.
   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      ticks_in    = ticks_ff;
      semk_in     = semk_ff;
      pre_in      = pre_ff;
      hit_in      = hit_ff;
      count_in    = count_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      exp_in      = exp_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_ff[IDX_W-1:0];
      mem_wdata   = mem_q;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               id_in    = req_id;
               ticks_in = req_ticks;
               semk_in  = (req_kind == WAIT_SEM_TIMEOUT);
               pre_in   = pre_status;
               hit_in   = 1'b0;
               rd_in    = '0;
               wr_in    = '0;
               exp_in   = '0;
            end
         end
         S_READ: begin
         end
         S_EVAL: begin
            if (!stall) begin
               // Kept entries are written back compacted toward the head.
               if (!drop) begin
                  mem_we    = 1'b1;
                  mem_wdata = mem_q;
                  if (op_ff == REQ_TICK) begin
                     mem_wdata.rem = rem_dec;
                  end
                  wr_in = wr_ff + 1'b1;
               end
               if (op_ff != REQ_TICK && mem_q.task_id == id_ff) begin
                  hit_in = 1'b1;
               end
               if (op_ff == REQ_TICK && drop) begin
                  exp_in      = exp_ff + 1'b1;
                  rsp_load    = 1'b1;
                  rsp_data_in = {2'b00, 5'(count_ff - exp_ff - 1'b1), 5'd0, mem_q.sem,
                                 8'(mem_q.task_id), ST_OK};
               end
               rd_in = rd_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               if (pre_ff != ST_OK) begin
                  rsp_data_in = {2'b00, 5'(count_ff), 5'd0, 1'b0, 8'd0, pre_ff};
               end else if (op_ff == REQ_TICK) begin
                  count_in    = wr_ff;
                  rsp_data_in = {2'b00, 5'(wr_ff), 5'(exp_ff), 1'b0, 8'd0, ST_OK};
               end else if (op_ff == REQ_REMOVE) begin
                  count_in    = wr_ff;
                  rsp_data_in = {2'b00, 5'(wr_ff), 5'd0, 1'b0, 8'd0,
                                 hit_ff ? ST_OK : ST_INVAL};
               end else if (hit_ff) begin
                  rsp_data_in = {2'b00, 5'(count_ff), 5'd0, 1'b0, 8'd0, ST_DUP};
               end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                  rsp_data_in = {2'b00, 5'(count_ff), 5'd0, 1'b0, 8'd0, ST_FULL};
               end else begin
                  // Append at the tail.
                  mem_we            = 1'b1;
                  mem_waddr         = count_ff[IDX_W-1:0];
                  mem_wdata.task_id = id_ff;
                  mem_wdata.rem     = ticks_ff;
                  mem_wdata.sem     = semk_ff;
                  count_in          = count_ff + 1'b1;
                  rsp_data_in = {2'b00, 5'(count_ff + 1'b1), 5'd0, 1'b0, 8'd0, ST_OK};
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_READ) begin
         mem_q <= entry_mem[rd_ff[IDX_W-1:0]];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= REQ_ENQUEUE;
         count_ff     <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         exp_ff       <= '0;
         hit_ff       <= 1'b0;
         pre_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         exp_ff   <= exp_in;
         hit_ff   <= hit_in;
         pre_ff   <= pre_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      ticks_ff <= ticks_in;
      semk_ff  <= semk_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The table never holds more entries than it has room for.
   `TDQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   // Compaction never writes ahead of the read position.
   `TDQ_ASSERT_ALWAYS(a_wr_behind_rd, clock, reset, wr_ff <= rd_ff)
   // During a tick every entry scanned is either kept or expired.
   `TDQ_ASSERT_IMPLIES(a_tick_balance, clock, reset, op_ff == REQ_TICK && state_ff != S_IDLE, wr_ff + exp_ff == rd_ff)
   // A new beat is loaded only when the result register is free.
   `TDQ_ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_load, out_free)
   // The closing beat returns the sequencer to idle.
   `TDQ_ASSERT_NEXT(a_finish_idle, clock, reset, state_ff == S_FINISH && out_free, state_ff == S_IDLE)

endmodule

`default_nettype wire
